FILE: rtl/core/gamepad_report_delta_events_unit_macros.svh
// Assertion macros for the gamepad report delta events unit.
// Each macro expects clk and rst in the scope where it is used.
`ifndef GAMEPAD_REPORT_DELTA_EVENTS_UNIT_MACROS_SVH
`define GAMEPAD_REPORT_DELTA_EVENTS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GRDE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GRDE_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define GRDE_ASSERT_IMPLY(label, ante, cons, msg)
`define GRDE_ASSERT_NEVER(label, cond, msg)
`endif
`endif

FILE: rtl/core/grde_pkg.sv
// Shared types, constants and helper functions of the gamepad report delta events unit.
// No dependencies.
package grde_pkg;

  localparam int DEVICE_SLOTS_DEF = 8;
  localparam int QUEUE_DEPTH      = 2;
  localparam int EVENT_SLOTS      = 32;
  localparam int BUTTON_COUNT     = 24;
  localparam int AXIS_COUNT       = 8;

  localparam logic [7:0]  GOOD_LENGTH = 8'h40;
  localparam logic [15:0] GOOD_STATUS = 16'h013c;
  localparam int TOUCH_POS = 3;
  localparam int GUARD_POS = 6;
  localparam int MUTED_POS = 1;

  typedef enum logic [1:0] {
    KIND_DOWN = 2'd0,
    KIND_UP   = 2'd1,
    KIND_AXIS = 2'd2
  } ev_kind_t;

  typedef struct packed {
    logic signed [15:0] right_y;
    logic signed [15:0] right_x;
    logic signed [15:0] left_y;
    logic signed [15:0] left_x;
    logic [7:0]         trig_r;
    logic [7:0]         trig_l;
    logic [23:0]        button_bits;
    logic [15:0]        status_word;
    logic [7:0]         report_length;
    logic [2:0]         device_slot;
  } report_t;

  typedef struct packed {
    logic [63:0] axes;
    logic [15:0] triggers;
    logic [23:0] buttons;
  } slot_state_t;

  typedef struct packed {
    logic [AXIS_COUNT-1:0][15:0] values;
    logic [EVENT_SLOTS-1:0]      mask;
    logic [23:0]                 buttons;
    logic [2:0]                  slot;
  } job_t;

  typedef struct packed {
    logic [15:0] value;
    logic [4:0]  index;
    ev_kind_t    kind;
    logic [2:0]  device;
    logic        last;
  } event_t;

  // t*32767/255 as 128*t + floor(127*t/255)
  function automatic logic [15:0] scale_trigger(input logic [7:0] t);
    logic [14:0] y;
    logic [6:0]  q0;
    logic [8:0]  r;
    logic [6:0]  q;
    y  = 15'(t) * 15'd127;
    q0 = y[14:8];
    r  = {1'b0, y[7:0]} + {2'b00, q0};
    q  = q0 + ((r >= 9'd255) ? 7'd1 : 7'd0);
    return {1'b0, t, 7'b0} + {9'b0, q};
  endfunction

  function automatic logic [15:0] negate16(input logic [15:0] raw);
    if (raw == 16'h8000) begin
      return 16'h7fff;
    end
    return 16'h0000 - raw;
  endfunction

endpackage

FILE: rtl/core/grde_front.sv
// Front end: checks reports, keeps per-slot previous reports, builds event jobs.
// Depends on grde_pkg.
module grde_front #(
  parameter int DEVICE_SLOTS = grde_pkg::DEVICE_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  grde_pkg::report_t in_report,
  output logic              push_valid,
  input  logic              push_ready,
  output grde_pkg::job_t    push_job
);
  import grde_pkg::*;

  localparam int SLOT_W = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam logic [8:0] SLOT_LIMIT = 9'(DEVICE_SLOTS);

  slot_state_t             mem [DEVICE_SLOTS];
  logic [DEVICE_SLOTS-1:0] filled;

  logic        a_valid;
  report_t     a_rep;
  slot_state_t a_old;

  logic              accept;
  logic              good;
  logic              a_go;
  logic [SLOT_W-1:0] rd_idx;
  logic [SLOT_W-1:0] wr_idx;
  slot_state_t       new_state;
  logic [23:0]       changed;
  logic              touch_now;
  logic              touch_old;
  logic              lx_ch;
  logic              ly_ch;
  logic [15:0]       neg_ly;
  job_t              job;

  assign good = (in_report.report_length == GOOD_LENGTH) &&
                (in_report.status_word == GOOD_STATUS) &&
                ({6'b0, in_report.device_slot} < SLOT_LIMIT);
  assign accept   = in_valid && in_ready;
  assign rd_idx   = SLOT_W'(in_report.device_slot);
  assign wr_idx   = SLOT_W'(a_rep.device_slot);
  assign a_go     = a_valid && ((job.mask == '0) || push_ready);
  assign in_ready = !a_valid || a_go;

  assign new_state.buttons  = a_rep.button_bits;
  assign new_state.triggers = {a_rep.trig_r, a_rep.trig_l};
  assign new_state.axes     = {a_rep.right_y, a_rep.right_x, a_rep.left_y, a_rep.left_x};

  always_comb begin
    changed = a_rep.button_bits ^ a_old.buttons;
    if (changed[GUARD_POS]) begin
      changed[MUTED_POS] = 1'b0;
    end
    touch_now = a_rep.button_bits[TOUCH_POS];
    touch_old = a_old.buttons[TOUCH_POS];
    lx_ch     = a_rep.left_x != a_old.axes[15:0];
    ly_ch     = a_rep.left_y != a_old.axes[31:16];
    neg_ly    = negate16(a_rep.left_y);

    job.slot    = a_rep.device_slot;
    job.buttons = a_rep.button_bits;
    for (int k = 0; k < BUTTON_COUNT; k++) begin
      job.mask[k] = changed[BUTTON_COUNT-1-k];
    end
    job.mask[BUTTON_COUNT+0] = a_rep.trig_l != a_old.triggers[7:0];
    job.mask[BUTTON_COUNT+1] = a_rep.trig_r != a_old.triggers[15:8];
    job.mask[BUTTON_COUNT+2] = (touch_now || touch_old) && lx_ch;
    job.mask[BUTTON_COUNT+3] = (touch_now || touch_old) && ly_ch;
    job.mask[BUTTON_COUNT+4] = a_rep.right_x != a_old.axes[47:32];
    job.mask[BUTTON_COUNT+5] = a_rep.right_y != a_old.axes[63:48];
    job.mask[BUTTON_COUNT+6] = touch_now ? !touch_old : lx_ch;
    job.mask[BUTTON_COUNT+7] = touch_now ? !touch_old : ly_ch;

    job.values[0] = scale_trigger(a_rep.trig_l);
    job.values[1] = scale_trigger(a_rep.trig_r);
    job.values[2] = a_rep.left_x;
    job.values[3] = neg_ly;
    job.values[4] = a_rep.right_x;
    job.values[5] = negate16(a_rep.right_y);
    job.values[6] = touch_now ? 16'h0000 : a_rep.left_x;
    job.values[7] = touch_now ? 16'h0000 : neg_ly;
  end

  assign push_valid = a_valid && (job.mask != '0);
  assign push_job   = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      filled  <= '0;
    end else begin
      if (accept && good) begin
        a_valid <= 1'b1;
      end else if (a_go) begin
        a_valid <= 1'b0;
      end
      if (a_go) begin
        filled[wr_idx] <= 1'b1;
      end
    end
  end

  // forward the state being written when the same slot is read back to back
  always_ff @(posedge clk) begin
    if (a_go) begin
      mem[wr_idx] <= new_state;
    end
    if (accept && good) begin
      a_rep <= in_report;
      if (a_go && (rd_idx == wr_idx)) begin
        a_old <= new_state;
      end else if (filled[rd_idx]) begin
        a_old <= mem[rd_idx];
      end else begin
        a_old <= '0;
      end
    end
  end

endmodule

FILE: rtl/core/grde_queue.sv
// Short job queue between the front and back ends.
// Depends on grde_pkg.
module grde_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  grde_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output grde_pkg::job_t pop_job
);
  import grde_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != FULL_CNT;
  assign pop_valid  = count != '0;
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: rtl/core/grde_back.sv
// Back end: walks a job's event mask and issues one event per cycle, unless stalled, into the output register.
// Depends on grde_pkg and the assertion macro header.
`include "gamepad_report_delta_events_unit_macros.svh"
module grde_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  grde_pkg::job_t     pop_job,
  output logic               out_valid,
  input  logic               out_ready,
  output grde_pkg::event_t   out_event
);
  import grde_pkg::*;

  logic                   busy;
  logic [EVENT_SLOTS-1:0] mask;
  job_t                   job;
  event_t                 o_event;
  logic                   o_valid;

  logic [4:0]             sel;
  logic [EVENT_SLOTS-1:0] mask_next;
  logic                   last;
  logic                   adv;
  logic                   emit;
  event_t                 ev;

  always_comb begin
    sel = '0;
    for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = 5'(i);
      end
    end
    mask_next      = mask & ~(EVENT_SLOTS'(1) << sel);
    last           = mask_next == '0;
    ev.device      = job.slot;
    ev.last        = last;
    if (sel < 5'(BUTTON_COUNT)) begin
      ev.kind  = job.buttons[5'(BUTTON_COUNT - 1) - sel] ? KIND_DOWN : KIND_UP;
      ev.index = sel;
      ev.value = '0;
    end else begin
      ev.kind  = KIND_AXIS;
      ev.index = sel - 5'(BUTTON_COUNT);
      ev.value = job.values[sel[2:0]];
    end
  end

  assign adv       = !o_valid || out_ready;
  assign emit      = adv && busy;
  assign pop_ready = !busy || (emit && last);
  assign out_valid = o_valid;
  assign out_event = o_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (adv) begin
        o_valid <= busy;
      end
      if (pop_valid && pop_ready) begin
        busy <= 1'b1;
      end else if (emit && last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job  <= pop_job;
      mask <= pop_job.mask;
    end else if (emit) begin
      mask <= mask_next;
    end
    if (emit) begin
      o_event <= ev;
    end
  end

  `GRDE_ASSERT_NEVER(busy_has_work, busy && (mask == '0), "active job with empty event mask")
  `GRDE_ASSERT_IMPLY(axis_index_range, o_valid && (o_event.kind == KIND_AXIS), o_event.index < 5'(AXIS_COUNT), "axis event index out of range")
  `GRDE_ASSERT_IMPLY(button_value_zero, o_valid && (o_event.kind != KIND_AXIS), o_event.value == '0, "button event with nonzero value")

endmodule

FILE: rtl/core/gamepad_report_delta_events_unit.sv
// Top level of the gamepad report delta events unit: stream ports, front end, queue, back end.
// Depends on grde_pkg, grde_front, grde_queue and grde_back.
//
//   port group  dir  payload
//   s_*         in   report: tdata only
//   m_*         out  event: tdata, tuser = kind, tlast = last event of a report
//
// A report is taken every cycle while the job queue has room; bad reports are dropped on entry.
// Each report is checked on acceptance and compared in the front stage in the cycle after.
// The back end issues one event per cycle unless stalled; a report holds it until its last event.
// A report's first event passes the front stage, a queue slot, the job and output registers.
// Reset clears the per-slot valid bits at once; no clearing pass.
module gamepad_report_delta_events_unit #(
  parameter int DEVICE_SLOTS = grde_pkg::DEVICE_SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // device_slot, report_length, status_word, button_bits, trig_l,
  // trig_r, left_x, left_y, right_x, right_y, zero fill
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // event_device, event_index, event_value
  output logic [23:0]  m_tdata,
  // event_kind
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);
  import grde_pkg::*;

  report_t report;
  logic    push_valid;
  logic    push_ready;
  job_t    push_job;
  logic    pop_valid;
  logic    pop_ready;
  job_t    pop_job;
  event_t  ev;

  assign report.device_slot   = s_tdata[2:0];
  assign report.report_length = s_tdata[10:3];
  assign report.status_word   = s_tdata[26:11];
  assign report.button_bits   = s_tdata[50:27];
  assign report.trig_l        = s_tdata[58:51];
  assign report.trig_r        = s_tdata[66:59];
  assign report.left_x        = s_tdata[82:67];
  assign report.left_y        = s_tdata[98:83];
  assign report.right_x       = s_tdata[114:99];
  assign report.right_y       = s_tdata[130:115];

  grde_front #(
    .DEVICE_SLOTS(DEVICE_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_report (report),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job)
  );

  grde_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_job  (push_job),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job)
  );

  grde_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_job  (pop_job),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_event(ev)
  );

  assign m_tdata = {ev.value, ev.index, ev.device};
  assign m_tuser = ev.kind;
  assign m_tlast = ev.last;

endmodule

FILE: bench/gamepad_report_delta_events_unit_tb.sv
// Testbench of gamepad_report_delta_events_unit: directed table, then random reports
// under changing back-pressure, events checked by table or per-slot delta predictor.
// Depends on grde_pkg and the RTL of the unit.
module gamepad_report_delta_events_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import grde_pkg::*;

  localparam int SLOTS       = DEVICE_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PREDICT     = -1;
  localparam int MAX_SHOWN   = 10;

  typedef struct packed {
    logic [2:0]  device;
    ev_kind_t    kind;
    logic [4:0]  index;
    logic [15:0] value;
    logic        last;
  } delta_event_t;

  typedef struct {
    report_t     rep;
    int          typed_count;
    ev_kind_t    kind;
    logic [4:0]  index;
    logic [15:0] value;
  } stimulus_row_t;

  typedef enum int {
    PH_DIRECTED, PH_PRESSURE, PH_FREE, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH_IDLE,
    PH_DRAIN
  } phase_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [23:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  phase_t        phase = PH_DIRECTED;
  report_t       stored_report [SLOTS] = '{default: '0};
  delta_event_t  fresh_events [$];
  delta_event_t  pending_events [$];
  stimulus_row_t directed_rows [$];
  int            mismatch_count = 0;

  gamepad_report_delta_events_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  function automatic int sender_gap_pct(input phase_t ph);
    case (ph)
      PH_SENDER_IDLE: return 65;
      PH_BOTH_IDLE:   return 15;
      default:        return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input phase_t ph);
    case (ph)
      PH_RECEIVER_STALL: return 65;
      PH_BOTH_IDLE:      return 15;
      default:           return 0;
    endcase
  endfunction

  function automatic logic [15:0] trigger_scaled(input logic [7:0] t);
    return 16'((32'(t) * 32'd32767) / 32'd255);
  endfunction

  function automatic logic [15:0] flip_y(input logic [15:0] v);
    if (v == 16'h8000) begin
      return 16'h7fff;
    end
    return (~v) + 16'd1;
  endfunction

  function automatic void add_event(input logic [2:0] dev, input ev_kind_t kind,
                                    input logic [4:0] idx, input logic [15:0] val);
    fresh_events.push_back('{device: dev, kind: kind, index: idx, value: val, last: 1'b0});
  endfunction

  // Fill fresh_events with the events of one report and store it; 0 when dropped.
  function automatic bit predict_events(input report_t r);
    report_t     prior;
    logic [23:0] flips;
    logic [2:0]  dev;
    bit          touch_now;
    bit          touch_was;
    int          k;
    fresh_events.delete();
    if (r.report_length != GOOD_LENGTH || r.status_word != GOOD_STATUS ||
        int'(r.device_slot) >= SLOTS) begin
      return 1'b0;
    end
    dev   = r.device_slot;
    prior = stored_report[dev];
    flips = r.button_bits ^ prior.button_bits;
    if (flips[GUARD_POS]) begin
      flips[MUTED_POS] = 1'b0;
    end
    for (k = 0; k < BUTTON_COUNT; k++) begin
      if (flips[23-k]) begin
        add_event(dev, r.button_bits[23-k] ? KIND_DOWN : KIND_UP, 5'(k), '0);
      end
    end
    if (r.trig_l != prior.trig_l) begin
      add_event(dev, KIND_AXIS, 5'd0, trigger_scaled(r.trig_l));
    end
    if (r.trig_r != prior.trig_r) begin
      add_event(dev, KIND_AXIS, 5'd1, trigger_scaled(r.trig_r));
    end
    touch_now = r.button_bits[TOUCH_POS];
    touch_was = prior.button_bits[TOUCH_POS];
    if (touch_now || touch_was) begin
      if (r.left_x != prior.left_x) begin
        add_event(dev, KIND_AXIS, 5'd2, r.left_x);
      end
      if (r.left_y != prior.left_y) begin
        add_event(dev, KIND_AXIS, 5'd3, flip_y(r.left_y));
      end
    end
    if (r.right_x != prior.right_x) begin
      add_event(dev, KIND_AXIS, 5'd4, r.right_x);
    end
    if (r.right_y != prior.right_y) begin
      add_event(dev, KIND_AXIS, 5'd5, flip_y(r.right_y));
    end
    if (!touch_now) begin
      if (r.left_x != prior.left_x) begin
        add_event(dev, KIND_AXIS, 5'd6, r.left_x);
      end
      if (r.left_y != prior.left_y) begin
        add_event(dev, KIND_AXIS, 5'd7, flip_y(r.left_y));
      end
    end else if (!touch_was) begin
      add_event(dev, KIND_AXIS, 5'd6, '0);
      add_event(dev, KIND_AXIS, 5'd7, '0);
    end
    stored_report[dev] = r;
    if (fresh_events.size() > 0) begin
      fresh_events[fresh_events.size()-1].last = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic report_t mk_report(input logic [2:0] slot, input logic [7:0] len,
                                        input logic [15:0] status, input logic [23:0] buttons,
                                        input logic [7:0] lt, input logic [7:0] rt,
                                        input logic [15:0] lx, input logic [15:0] ly,
                                        input logic [15:0] rx, input logic [15:0] ry);
    report_t r;
    r.device_slot   = slot;
    r.report_length = len;
    r.status_word   = status;
    r.button_bits   = buttons;
    r.trig_l        = lt;
    r.trig_r        = rt;
    r.left_x        = lx;
    r.left_y        = ly;
    r.right_x       = rx;
    r.right_y       = ry;
    return r;
  endfunction

  function automatic void add_row(input report_t rep, input int n, input ev_kind_t kind,
                                  input logic [4:0] idx, input logic [15:0] val);
    directed_rows.push_back('{rep: rep, typed_count: n, kind: kind, index: idx, value: val});
  endfunction

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_trigger();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly small deltas on the stored report of a slot; some broken reports.
  function automatic report_t random_report();
    report_t    r;
    int         roll;
    logic [2:0] slot;
    slot = 3'($urandom_range(SLOTS - 1));
    r    = stored_report[slot];
    r.device_slot   = slot;
    r.report_length = GOOD_LENGTH;
    r.status_word   = GOOD_STATUS;
    roll = $urandom_range(99);
    if (roll < 12) begin
      case ($urandom_range(3))
        0: r.report_length = 8'($urandom);
        1: r.status_word = GOOD_STATUS ^ (16'd1 << $urandom_range(15));
        2: r.report_length = GOOD_LENGTH ^ (8'd1 << $urandom_range(7));
        default: begin
          r.report_length = 8'($urandom);
          r.status_word   = 16'($urandom);
        end
      endcase
      r.button_bits = 24'($urandom);
      return r;
    end
    if (roll < 20) begin
      return r;
    end
    if ($urandom_range(99) < 20) begin
      r.button_bits = 24'($urandom);
    end else begin
      repeat ($urandom_range(3)) r.button_bits[$urandom_range(23)] ^= 1'b1;
    end
    if ($urandom_range(99) < 25) begin
      r.button_bits[TOUCH_POS] ^= 1'b1;
    end
    if ($urandom_range(99) < 15) begin
      r.button_bits[GUARD_POS] ^= 1'b1;
      r.button_bits[MUTED_POS] ^= 1'b1;
    end
    if ($urandom_range(99) < 40) r.trig_l = pick_trigger();
    if ($urandom_range(99) < 40) r.trig_r = pick_trigger();
    if ($urandom_range(99) < 40) r.left_x = pick_axis();
    if ($urandom_range(99) < 40) r.left_y = pick_axis();
    if ($urandom_range(99) < 40) r.right_x = pick_axis();
    if ($urandom_range(99) < 40) r.right_y = pick_axis();
    return r;
  endfunction

  task automatic offer_report(input report_t r);
    @(negedge clk);
    while ($urandom_range(99) < sender_gap_pct(phase)) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, r};
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
  endtask

  function automatic string show(input delta_event_t e);
    return $sformatf("dev %0d kind %0d idx %0d val %0d last %0d",
                     e.device, e.kind, e.index, $signed(e.value), e.last);
  endfunction

  function automatic void flag_mismatch(input string what, input delta_event_t want,
                                        input delta_event_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("%s: expected %s, got %s", what, show(want), show(got));
    end
  endfunction

  always @(posedge clk) begin : event_check
    delta_event_t got;
    delta_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{device: m_tdata[2:0], kind: ev_kind_t'(m_tuser), index: m_tdata[7:3],
              value: m_tdata[23:8], last: m_tlast};
      if (pending_events.size() == 0) begin
        flag_mismatch("unexpected event", '0, got);
      end else begin
        want = pending_events.pop_front();
        if (got !== want) begin
          flag_mismatch("event mismatch", want, got);
        end
      end
    end
  end

  initial begin : receiver
    int hold;
    bit pressure_done;
    hold = 0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == PH_PRESSURE && !pressure_done) begin
        hold = 400;
        pressure_done = 1'b1;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct(phase));
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    phase_t        plan [5];
    int            plan_items [5];
    stimulus_row_t row;
    report_t       r;
    int            taken;
    int            p;
    plan       = '{PH_PRESSURE, PH_FREE, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH_IDLE};
    plan_items = '{40, 60, 70, 70, 60};

    // bad length, bad status
    add_row(mk_report(3'd0, 8'd63, GOOD_STATUS, 24'hffffff, 8'hff, 8'hff,
                      16'h7fff, 16'h8000, 16'h7fff, 16'h8000), 0, KIND_DOWN, '0, '0);
    add_row(mk_report(3'd0, GOOD_LENGTH, 16'h013d, 24'hffffff, 8'hff, 8'hff,
                      16'h7fff, 16'h8000, 16'h7fff, 16'h8000), 0, KIND_DOWN, '0, '0);
    // single button, trigger and right pad steps from the cleared store
    add_row(mk_report(3'd0, GOOD_LENGTH, GOOD_STATUS, 24'h800000, 8'h00, 8'h00,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000), 1, KIND_DOWN, 5'd0, '0);
    add_row(mk_report(3'd0, GOOD_LENGTH, GOOD_STATUS, 24'h000000, 8'h00, 8'h00,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000), 1, KIND_UP, 5'd0, '0);
    add_row(mk_report(3'd1, GOOD_LENGTH, GOOD_STATUS, 24'h000000, 8'hff, 8'h00,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000), 1, KIND_AXIS, 5'd0, 16'h7fff);
    add_row(mk_report(3'd1, GOOD_LENGTH, GOOD_STATUS, 24'h000000, 8'hff, 8'hff,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000), 1, KIND_AXIS, 5'd1, 16'h7fff);
    add_row(mk_report(3'd2, GOOD_LENGTH, GOOD_STATUS, 24'h000000, 8'h00, 8'h00,
                      16'h0000, 16'h0000, 16'h0000, 16'h8000), 1, KIND_AXIS, 5'd5, 16'h7fff);
    add_row(mk_report(3'd2, GOOD_LENGTH, GOOD_STATUS, 24'h000000, 8'h00, 8'h00,
                      16'h0000, 16'h0000, 16'h7fff, 16'h8000), 1, KIND_AXIS, 5'd4, 16'h7fff);
    add_row(mk_report(3'd3, GOOD_LENGTH, GOOD_STATUS, 24'h000000, 8'h00, 8'h00,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000), 0, KIND_DOWN, '0, '0);
    // everything at once, with suppression and first touch
    add_row(mk_report(3'd0, GOOD_LENGTH, GOOD_STATUS, 24'hffffff, 8'hff, 8'hff,
                      16'h7fff, 16'h8000, 16'h8000, 16'h7fff), PREDICT, KIND_DOWN, '0, '0);
    add_row(mk_report(3'd0, GOOD_LENGTH, GOOD_STATUS, 24'h000000, 8'h00, 8'h00,
                      16'h8000, 16'h7fff, 16'h7fff, 16'h8000), PREDICT, KIND_DOWN, '0, '0);
    add_row(mk_report(3'd4, GOOD_LENGTH, GOOD_STATUS, 24'h000042, 8'h01, 8'hfe,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000), PREDICT, KIND_DOWN, '0, '0);
    add_row(mk_report(3'd4, GOOD_LENGTH, GOOD_STATUS, 24'h000040, 8'h01, 8'hfe,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000), PREDICT, KIND_DOWN, '0, '0);
    // touch, hold, release
    add_row(mk_report(3'd5, GOOD_LENGTH, GOOD_STATUS, 24'h000008, 8'h00, 8'h00,
                      16'd100, 16'hfffb, 16'h0000, 16'h0000), PREDICT, KIND_DOWN, '0, '0);
    add_row(mk_report(3'd5, GOOD_LENGTH, GOOD_STATUS, 24'h000008, 8'h00, 8'h00,
                      16'h8000, 16'h8000, 16'h0000, 16'h0000), PREDICT, KIND_DOWN, '0, '0);
    add_row(mk_report(3'd5, GOOD_LENGTH, GOOD_STATUS, 24'h000000, 8'h00, 8'h00,
                      16'd7, 16'h8000, 16'h0000, 16'h0000), PREDICT, KIND_DOWN, '0, '0);
    add_row(mk_report(3'd7, GOOD_LENGTH, GOOD_STATUS, 24'haaaaaa, 8'h01, 8'hfe,
                      16'h7fff, 16'h8000, 16'h8000, 16'h7fff), PREDICT, KIND_DOWN, '0, '0);
    add_row(mk_report(3'd7, 8'hff, 16'hffff, 24'h555555, 8'hfe, 8'h01,
                      16'h8000, 16'h7fff, 16'h7fff, 16'h8000), 0, KIND_DOWN, '0, '0);
    add_row(mk_report(3'd7, GOOD_LENGTH, 16'h0000, 24'h555555, 8'hfe, 8'h01,
                      16'h8000, 16'h7fff, 16'h7fff, 16'h8000), 0, KIND_DOWN, '0, '0);
    add_row(mk_report(3'd7, GOOD_LENGTH, GOOD_STATUS, 24'h555555, 8'hfe, 8'h01,
                      16'h8000, 16'h7fff, 16'h7fff, 16'h8000), PREDICT, KIND_DOWN, '0, '0);
    add_row(mk_report(3'd6, GOOD_LENGTH, GOOD_STATUS, 24'h000000, 8'h00, 8'h00,
                      16'h0000, 16'h0000, 16'h0000, 16'h0000), 0, KIND_DOWN, '0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      offer_report(row.rep);
      void'(predict_events(row.rep));
      if (row.typed_count == PREDICT) begin
        pending_events = {pending_events, fresh_events};
      end else if (row.typed_count > 0) begin
        pending_events.push_back('{device: row.rep.device_slot, kind: row.kind,
                                   index: row.index, value: row.value, last: 1'b1});
      end
    end

    for (p = 0; p < 5; p++) begin
      phase = plan[p];
      taken = 0;
      while (taken < plan_items[p]) begin
        r = random_report();
        offer_report(r);
        void'(predict_events(r));
        taken++;
        pending_events = {pending_events, fresh_events};
      end
    end

    phase = PH_DRAIN;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
